### design/dtp_pkg.sv
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types and constants for the timestamp text parser and validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtp_pkg;

  // One character of the timestamp text.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } dtp_in_t;

  // One parse result.
  typedef struct packed {
    logic        valid_res;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } dtp_out_t;

  localparam logic [4:0] TS_LEN  = 5'd16;
  localparam logic [4:0] POS_SAT = 5'd17;

  // Character positions of the separators and of the two low year digits.
  localparam logic [4:0] POS_YEAR_SEP  = 5'd4;
  localparam logic [4:0] POS_MONTH_SEP = 5'd7;
  localparam logic [4:0] POS_DAY_SEP   = 5'd10;
  localparam logic [4:0] POS_HOUR_SEP  = 5'd13;
  localparam logic [4:0] POS_YEAR_D2   = 5'd2;
  localparam logic [4:0] POS_YEAR_D3   = 5'd3;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [13:0] YEAR_MIN   = 14'd1000;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [6:0]  MONTH_MAX  = 7'd12;
  localparam logic [6:0]  MONTH_FEB  = 7'd2;
  localparam logic [6:0]  MONTH_APR  = 7'd4;
  localparam logic [6:0]  MONTH_JUN  = 7'd6;
  localparam logic [6:0]  MONTH_SEP  = 7'd9;
  localparam logic [6:0]  MONTH_NOV  = 7'd11;
  localparam logic [4:0]  DAYS_LONG  = 5'd31;
  localparam logic [4:0]  DAYS_SHORT = 5'd30;
  localparam logic [4:0]  DAYS_LEAP  = 5'd29;
  localparam logic [4:0]  DAYS_FEB   = 5'd28;
  localparam logic [6:0]  HOUR_MAX   = 7'd23;
  localparam logic [13:0] MINUTE_MAX = 14'd59;

endpackage : dtp_pkg

`default_nettype wire

### design/datetime_text_parse_validate.sv
// ----------------------------------------------------------------------------
// datetime_text_parse_validate
// Parses YYYY-MM-DD/HH:MM text, one character per transfer, and checks the
// format and the Gregorian calendar; one result per flagged last character.
// ----------------------------------------------------------------------------
//  Channel | Ports                         | Payload   | Transfers
//  --------+-------------------------------+-----------+-------------------------
//  input   | in_valid, in_stall, in_data   | dtp_in_t  | one per character
//  result  | out_valid, out_stall, out_data| dtp_out_t | one per last character
//
//  One character is taken every cycle while no last character waits on a held
//  result. A character is registered on its transfer; its processing then updates
//  the parse state and, for a last character, loads the result register, from
//  which the result is offered.
//  Only a last character waits on a held result; other characters keep flowing.
//  Reset clears the parse state and both valid flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module datetime_text_parse_validate
  import dtp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dtp_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output dtp_out_t      out_data
);

  logic     inq_valid_r;
  dtp_in_t  inq_r;
  logic     out_valid_r;
  dtp_out_t out_data_r;

  logic [4:0]  pos_r,     pos_nxt;
  logic        bad_r,     bad_nxt;
  logic [13:0] accum_r,   accum_nxt;
  logic [13:0] year_r,    year_nxt;
  logic [6:0]  month_r,   month_nxt;
  logic [6:0]  day_r,     day_nxt;
  logic [6:0]  hour_r,    hour_nxt;
  logic [1:0]  century_r, century_nxt;
  logic [6:0]  yr_lo_r,   yr_lo_nxt;

  logic        proc;
  logic        is_digit;
  logic [3:0]  digit;
  logic [13:0] accum_x10;
  logic [7:0]  sep_ch;
  logic        leap;
  logic [4:0]  dmax;
  logic        ok;
  dtp_out_t    res;

  // A non-last character never touches the result register.
  assign proc     = inq_valid_r && (!inq_r.last || !out_valid_r || !out_stall);
  assign in_stall = inq_valid_r && !proc;

  assign is_digit  = (inq_r.ch >= CH_ZERO) && (inq_r.ch <= CH_NINE);
  assign digit     = inq_r.ch[3:0];
  assign accum_x10 = {accum_r[10:0], 3'b000} + {accum_r[12:0], 1'b0};

  always_comb begin
    priority if (pos_r == POS_DAY_SEP) begin
      sep_ch = CH_SLASH;
    end else if (pos_r == POS_HOUR_SEP) begin
      sep_ch = CH_COLON;
    end else begin
      sep_ch = CH_DASH;
    end
  end

  always_comb begin
    bad_nxt     = bad_r;
    accum_nxt   = accum_r;
    year_nxt    = year_r;
    month_nxt   = month_r;
    day_nxt     = day_r;
    hour_nxt    = hour_r;
    century_nxt = century_r;
    yr_lo_nxt   = yr_lo_r;
    pos_nxt     = (pos_r >= TS_LEN) ? POS_SAT : pos_r + 5'd1;
    if (pos_r < TS_LEN) begin
      if (pos_r == POS_YEAR_SEP || pos_r == POS_MONTH_SEP ||
          pos_r == POS_DAY_SEP || pos_r == POS_HOUR_SEP) begin
        if (inq_r.ch != sep_ch) begin
          bad_nxt = 1'b1;
        end else begin
          priority if (pos_r == POS_YEAR_SEP) begin
            year_nxt = accum_r;
          end else if (pos_r == POS_MONTH_SEP) begin
            month_nxt = accum_r[6:0];
          end else if (pos_r == POS_DAY_SEP) begin
            day_nxt = accum_r[6:0];
          end else begin
            hour_nxt = accum_r[6:0];
          end
          accum_nxt = '0;
        end
      end else if (is_digit) begin
        accum_nxt = accum_x10 + {10'd0, digit};
        // The two low year digits are kept apart for the leap-year test;
        // of the century only its remainder by four matters.
        if (pos_r == POS_YEAR_D2) begin
          century_nxt = accum_r[1:0];
          yr_lo_nxt   = {3'd0, digit};
        end else if (pos_r == POS_YEAR_D3) begin
          yr_lo_nxt = {yr_lo_r[3:0], 3'b000} + {yr_lo_r[5:0], 1'b0} + {3'd0, digit};
        end
      end else begin
        bad_nxt = 1'b1;
      end
    end
  end

  // With a clean format the year is exactly century * 100 + low two digits.
  assign leap = (yr_lo_r == 7'd0) ? (century_r == 2'b00) : (yr_lo_r[1:0] == 2'b00);

  always_comb begin
    if (month_r == MONTH_APR || month_r == MONTH_JUN ||
        month_r == MONTH_SEP || month_r == MONTH_NOV) begin
      dmax = DAYS_SHORT;
    end else if (month_r == MONTH_FEB) begin
      dmax = leap ? DAYS_LEAP : DAYS_FEB;
    end else begin
      dmax = DAYS_LONG;
    end
  end

  assign ok = (pos_nxt == TS_LEN) && !bad_nxt &&
              (year_r >= YEAR_MIN) && (year_r <= YEAR_MAX) &&
              (month_r >= 7'd1) && (month_r <= MONTH_MAX) &&
              (day_r >= 7'd1) && (day_r <= {2'b00, dmax}) &&
              (hour_r <= HOUR_MAX) && (accum_nxt <= MINUTE_MAX);

  always_comb begin
    res = '0;
    if (ok) begin
      res.valid_res = 1'b1;
      res.year      = year_r;
      res.month     = month_r[3:0];
      res.day       = day_r[4:0];
      res.hour      = hour_r[4:0];
      res.minute    = accum_nxt[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      inq_valid_r <= 1'b1;
    end else if (proc) begin
      inq_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      inq_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (proc && inq_r.last)) begin
      pos_r     <= '0;
      bad_r     <= 1'b0;
      accum_r   <= '0;
      year_r    <= '0;
      month_r   <= '0;
      day_r     <= '0;
      hour_r    <= '0;
      century_r <= '0;
      yr_lo_r   <= '0;
    end else if (proc) begin
      pos_r     <= pos_nxt;
      bad_r     <= bad_nxt;
      accum_r   <= accum_nxt;
      year_r    <= year_nxt;
      month_r   <= month_nxt;
      day_r     <= day_nxt;
      hour_r    <= hour_nxt;
      century_r <= century_nxt;
      yr_lo_r   <= yr_lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && inq_r.last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && inq_r.last) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : datetime_text_parse_validate

`default_nettype wire

### design/dtp_checker.sv
// ----------------------------------------------------------------------------
// dtp_checker
// Port-level checks on the results of the timestamp parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtp_checker
  import dtp_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire dtp_out_t out_data
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A failed parse reports all fields as zero.
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |->
      out_data.year == 14'd0 && out_data.month == 4'd0 && out_data.day == 5'd0 &&
      out_data.hour == 5'd0 && out_data.minute == 6'd0)
    else $error("invalid result carries nonzero fields");

  // A passed parse lies inside the calendar ranges.
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.valid_res |->
      out_data.year >= YEAR_MIN && out_data.year <= YEAR_MAX &&
      out_data.month >= 4'd1 && out_data.month <= 4'd12 &&
      out_data.day >= 5'd1 && out_data.hour <= 5'd23 && out_data.minute <= 6'd59)
    else $error("valid result out of range");

  // Short months and February never pass with too many days.
  a_month_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.valid_res &&
      (out_data.month == 4'd4 || out_data.month == 4'd6 ||
       out_data.month == 4'd9 || out_data.month == 4'd11) |->
      out_data.day <= 5'd30)
    else $error("day past end of a thirty-day month");

  a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.valid_res && out_data.month == 4'd2 |->
      out_data.day <= 5'd29 && (out_data.day != 5'd29 || out_data.year[1:0] == 2'b00))
    else $error("day past end of February");

endmodule : dtp_checker

bind datetime_text_parse_validate dtp_checker u_dtp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
